/* hdl/mrac_pkg.sv */
// shared types, constants and codes for the memory region access checker
// no dependencies; imported by mrac_cfg, mrac_classify and memory_region_access_checker

package mrac_pkg;

  localparam int ADDR_W = 24;
  localparam int MEM_BYTES = 1048576;
  localparam int RETURN_WORD_ADDR = 1024;

  localparam int VECTOR_END = 'h100;
  localparam int NAME_LO = 'h910;
  localparam int NAME_HI = 'h932;
  localparam int PARAM_BYTES = 32;

  localparam int BIT_AW = 5;
  localparam int ROW_BITS = 1 << BIT_AW;
  localparam int ROW_CNT = (MEM_BYTES + ROW_BITS - 1) / ROW_BITS;
  localparam int ROW_AW = (ROW_CNT > 1) ? $clog2(ROW_CNT) : 1;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [2:0] CFG_HEAP_START = 3'd0;
  localparam logic [2:0] CFG_HEAP_END = 3'd1;
  localparam logic [2:0] CFG_USTK_START = 3'd2;
  localparam logic [2:0] CFG_USTK_END = 3'd3;
  localparam logic [2:0] CFG_ISTK_START = 3'd4;
  localparam logic [2:0] CFG_ISTK_END = 3'd5;
  localparam logic [2:0] CFG_ABOVE = 3'd6;
  localparam logic [2:0] CFG_BELOW = 3'd7;

  localparam logic [3:0] REG_VECTORS = 4'd0;
  localparam logic [3:0] REG_GLOBALS = 4'd1;
  localparam logic [3:0] REG_APP_NAME = 4'd2;
  localparam logic [3:0] REG_HEAP = 4'd3;
  localparam logic [3:0] REG_USER_STACK = 4'd4;
  localparam logic [3:0] REG_BASE_WORD = 4'd5;
  localparam logic [3:0] REG_BELOW = 4'd6;
  localparam logic [3:0] REG_PARAMS = 4'd7;
  localparam logic [3:0] REG_ABOVE = 4'd8;
  localparam logic [3:0] REG_IRQ_STACK = 4'd9;
  localparam logic [3:0] REG_RETURN_WORD = 4'd10;
  localparam logic [3:0] REG_UNTRACKED = 4'd11;

  localparam logic [1:0] SEV_OK = 2'd0;
  localparam logic [1:0] SEV_WARN = 2'd1;
  localparam logic [1:0] SEV_FATAL = 2'd2;

  localparam logic REQ_READ = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] heap_start;
    logic [ADDR_W-1:0] heap_end;
    logic [ADDR_W-1:0] ustk_start;
    logic [ADDR_W-1:0] ustk_end;
    logic [ADDR_W-1:0] istk_start;
    logic [ADDR_W-1:0] istk_end;
    logic [ADDR_W:0]   base;
    logic [ADDR_W+1:0] above_end;
    logic [ADDR_W+1:0] param_end;
  } cfg_t;

  typedef struct packed {
    logic [3:0] region;
    logic [1:0] sev;
    logic       set_bit;
  } cls_t;

endpackage

/* hdl/mrac_ram.sv */
// generic single-write, single-read synchronous ram with registered read
// no dependencies

module mrac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

/* hdl/mrac_cfg.sv */
// apb register file with the derived globals-base bounds
// depends on mrac_pkg

module mrac_cfg
  import mrac_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output cfg_t              cfg
);

  logic [ADDR_W-1:0] regs_r [8];
  logic [ADDR_W:0]   base_r;
  logic [ADDR_W+1:0] above_end_r;
  logic [ADDR_W+1:0] param_end_r;
  logic              wr_en;
  logic [2:0]        idx;
  logic [ADDR_W-1:0] ustk_nxt;
  logic [ADDR_W-1:0] below_nxt;
  logic [ADDR_W-1:0] above_nxt;

  assign idx = paddr[CFG_AW-1:2];
  assign wr_en = psel && penable && pwrite;

  // derived bounds follow the register values written at the same edge
  assign ustk_nxt  = (wr_en && idx == CFG_USTK_START) ? pwdata[ADDR_W-1:0]
                                                      : regs_r[CFG_USTK_START];
  assign below_nxt = (wr_en && idx == CFG_BELOW) ? pwdata[ADDR_W-1:0] : regs_r[CFG_BELOW];
  assign above_nxt = (wr_en && idx == CFG_ABOVE) ? pwdata[ADDR_W-1:0] : regs_r[CFG_ABOVE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        regs_r[i] <= '0;
      end
      base_r <= '0;
      above_end_r <= '0;
      param_end_r <= '0;
    end else begin
      if (wr_en) begin
        regs_r[idx] <= pwdata[ADDR_W-1:0];
      end
      base_r <= {1'b0, ustk_nxt} + {1'b0, below_nxt};
      above_end_r <= {2'b00, ustk_nxt} + {2'b00, below_nxt} + {2'b00, above_nxt};
      param_end_r <= {2'b00, ustk_nxt} + {2'b00, below_nxt} + (ADDR_W+2)'(PARAM_BYTES);
    end
  end

  assign prdata = {{(CFG_DW-ADDR_W){1'b0}}, regs_r[idx]};

  assign cfg.heap_start = regs_r[CFG_HEAP_START];
  assign cfg.heap_end   = regs_r[CFG_HEAP_END];
  assign cfg.ustk_start = regs_r[CFG_USTK_START];
  assign cfg.ustk_end   = regs_r[CFG_USTK_END];
  assign cfg.istk_start = regs_r[CFG_ISTK_START];
  assign cfg.istk_end   = regs_r[CFG_ISTK_END];
  assign cfg.base       = base_r;
  assign cfg.above_end  = above_end_r;
  assign cfg.param_end  = param_end_r;

endmodule

/* hdl/mrac_classify.sv */
// region lookup and severity for one access, priority ordered
// depends on mrac_pkg

module mrac_classify
  import mrac_pkg::*;
(
  input  cfg_t              cfg,
  input  logic              req_type,
  input  logic [ADDR_W-1:0] address,
  input  logic              written,
  output cls_t              cls
);

  logic [ADDR_W+1:0] a_x;
  logic hit_vec, hit_glob, hit_name, hit_heap, hit_ustk, hit_base;
  logic hit_below, hit_area, hit_param, hit_istk, hit_ret;
  logic wr;

  assign wr  = (req_type == REQ_WRITE);
  assign a_x = {2'b00, address};

  assign hit_vec   = a_x < (ADDR_W+2)'(VECTOR_END);
  assign hit_glob  = (address < cfg.heap_start);
  assign hit_name  = (a_x >= (ADDR_W+2)'(NAME_LO)) && (a_x < (ADDR_W+2)'(NAME_HI));
  assign hit_heap  = (address >= cfg.heap_start) && (address < cfg.heap_end);
  assign hit_ustk  = (address > cfg.ustk_end) && (address <= cfg.ustk_start);
  assign hit_base  = (a_x == {1'b0, cfg.base});
  assign hit_below = (address >= cfg.ustk_start) && (a_x < {1'b0, cfg.base});
  assign hit_area  = (a_x >= {1'b0, cfg.base}) && (a_x < cfg.above_end);
  assign hit_param = (a_x < cfg.param_end);
  assign hit_istk  = (address > cfg.istk_end) && (address <= cfg.istk_start);
  assign hit_ret   = (a_x == (ADDR_W+2)'(RETURN_WORD_ADDR));

  always_comb begin
    cls.set_bit = 1'b0;
    if (hit_vec) begin
      cls.region = REG_VECTORS;
      cls.sev = wr ? SEV_FATAL : SEV_OK;
    end else if (hit_glob) begin
      cls.region = hit_name ? REG_APP_NAME : REG_GLOBALS;
      cls.sev = (wr || !hit_name) ? SEV_WARN : SEV_OK;
    end else if (hit_heap) begin
      cls.region = REG_HEAP;
      cls.sev = wr ? SEV_WARN : SEV_OK;
    end else if (hit_ustk) begin
      cls.region = REG_USER_STACK;
      cls.sev = SEV_OK;
    end else if (hit_base) begin
      cls.region = REG_BASE_WORD;
      cls.sev = SEV_WARN;
    end else if (hit_below) begin
      cls.region = REG_BELOW;
      cls.set_bit = wr;
      cls.sev = (wr || written) ? SEV_OK : SEV_WARN;
    end else if (hit_area) begin
      cls.region = hit_param ? REG_PARAMS : REG_ABOVE;
      cls.sev = (hit_param || wr) ? SEV_WARN : SEV_OK;
    end else if (hit_istk) begin
      cls.region = REG_IRQ_STACK;
      cls.sev = SEV_OK;
    end else if (hit_ret) begin
      cls.region = REG_RETURN_WORD;
      cls.sev = wr ? SEV_FATAL : SEV_OK;
    end else begin
      cls.region = REG_UNTRACKED;
      cls.sev = SEV_FATAL;
    end
  end

endmodule

/* hdl/memory_region_access_checker.sv */
// memory region access checker: classifies each bus access of an emulated cpu
// by region and severity, tracking written bytes of the globals-below area.
// input stream: in_tdata = address, in_tuser = req_type (1 write, 0 read).
// output stream: out_tdata = region in [3:0], severity in [5:4].
// config: apb port, eight 24-bit registers at byte addresses 0x00..0x1c.
// pipeline: an accepted word is held in the access stage, then in the result
// register; one word per cycle sustained while out_tready is high. the map of
// written bytes is a ram of 32-bit rows read at accept and written back as the
// access stage advances; a back-to-back write to the same row is forwarded from
// a holding register. reset: config registers clear to zero, then the map is
// cleared by a pass of one row per cycle; in_tready stays low during that pass
// while config writes are taken as usual.
// stall: when out_tready is low the result register holds, the access stage
// holds behind it, and in_tready drops once both are full.
// depends on mrac_pkg, mrac_cfg, mrac_classify, mrac_ram

module memory_region_access_checker
  import mrac_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [23:0]       in_tdata,   // address[23:0]
  input  logic              in_tuser,   // req_type
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // region[3:0], severity[5:4], zero[7:6]
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;
  cls_t cls;

  logic              clr_act_r;
  logic [ROW_AW-1:0] clr_cnt_r;

  logic              p1_vld_r;
  logic              p1_wr_r;
  logic [ADDR_W-1:0] p1_addr_r;

  logic              fwd_vld_r;
  logic [ROW_AW-1:0] fwd_row_r;
  logic [ROW_BITS-1:0] fwd_data_r;

  logic              out_vld_r;
  logic [3:0]        out_region_r;
  logic [1:0]        out_sev_r;

  logic                in_acc;
  logic                p1_adv;
  logic [ROW_AW-1:0]   p1_row;
  logic [BIT_AW-1:0]   bit_idx;
  logic [ROW_BITS-1:0] ram_rdata;
  logic [ROW_BITS-1:0] row_data;
  logic [ROW_BITS-1:0] row_new;
  logic                in_map;
  logic                written;
  logic                map_wr;
  logic                ram_we;
  logic [ROW_AW-1:0]   ram_waddr;
  logic [ROW_BITS-1:0] ram_wdata;

  mrac_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready = 1'b1;

  assign p1_adv    = p1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !clr_act_r && (!p1_vld_r || p1_adv);
  assign in_acc    = in_tvalid && in_tready;

  assign p1_row  = p1_addr_r[ROW_AW+BIT_AW-1:BIT_AW];
  assign bit_idx = p1_addr_r[BIT_AW-1:0];
  assign in_map  = ({1'b0, p1_addr_r} < (ADDR_W+1)'(MEM_BYTES));

  assign row_data = (fwd_vld_r && fwd_row_r == p1_row) ? fwd_data_r : ram_rdata;
  assign written  = in_map && row_data[bit_idx];
  assign row_new  = row_data | (ROW_BITS'(1) << bit_idx);

  mrac_classify u_classify (
    .cfg      (cfg),
    .req_type (p1_wr_r),
    .address  (p1_addr_r),
    .written  (written),
    .cls      (cls)
  );

  assign map_wr    = p1_adv && cls.set_bit && in_map;
  assign ram_we    = clr_act_r || map_wr;
  assign ram_waddr = clr_act_r ? clr_cnt_r : p1_row;
  assign ram_wdata = clr_act_r ? '0 : row_new;

  mrac_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (ROW_CNT)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (in_tdata[ROW_AW+BIT_AW-1:BIT_AW]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_act_r <= 1'b1;
      clr_cnt_r <= '0;
      p1_vld_r  <= 1'b0;
      fwd_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (clr_act_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == ROW_AW'(ROW_CNT - 1)) begin
          clr_act_r <= 1'b0;
        end
      end
      if (in_acc) begin
        p1_vld_r <= 1'b1;
      end else if (p1_adv) begin
        p1_vld_r <= 1'b0;
      end
      if (map_wr) begin
        fwd_vld_r <= 1'b1;
      end
      if (p1_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p1_wr_r   <= in_tuser;
      p1_addr_r <= in_tdata;
    end
    if (map_wr) begin
      fwd_row_r  <= p1_row;
      fwd_data_r <= row_new;
    end
    if (p1_adv) begin
      out_region_r <= cls.region;
      out_sev_r    <= cls.sev;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'b00, out_sev_r, out_region_r};

`ifndef SYNTH
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_act_r |-> !in_tready)
    else $error("input accepted during map clear");

  a_fatal_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (p1_adv && cls.sev == SEV_FATAL) |-> !map_wr)
    else $error("fatal access changed the map");

  a_result_follows_stage: assert property (@(posedge clk) disable iff (!rst_n)
    p1_adv |=> out_tvalid && out_tdata[5:4] != 2'd3)
    else $error("result lost or bad severity code");
`endif

endmodule
